// ===== src/keyword_string_tokenizer_assert.svh =====
// Assertion macros used by the tokenizer back end.
`ifndef KEYWORD_STRING_TOKENIZER_ASSERT_SVH
`define KEYWORD_STRING_TOKENIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define KST_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tokenizer check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define KST_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tokenizer check failed");

`endif

// ===== src/kst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kst_pkg;

  localparam int LEN_W = 9;   // token length, covers up to 511 bytes
  localparam int ROW_W = 7;   // string memory row address, up to 128 rows
  localparam int NKEYS = 13;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_CHUNK = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_BAD     = 3'd0,
    ERR_LONG    = 3'd1,
    ERR_UNKNOWN = 3'd2,
    ERR_STRING  = 3'd3,
    ERR_EOF     = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    CC_EOF   = 3'd0,
    CC_SLASH = 3'd1,
    CC_STAR  = 3'd2,
    CC_DQ    = 3'd3,
    CC_SQ    = 3'd4,
    CC_ALPHA = 3'd5,
    CC_BLANK = 3'd6,
    CC_OTHER = 3'd7
  } cls_t;

  typedef enum logic [6:0] {
    LS_SCAN  = 7'b0000001,
    LS_SLASH = 7'b0000010,
    LS_CMT   = 7'b0000100,
    LS_STAR  = 7'b0001000,
    LS_DQ    = 7'b0010000,
    LS_SQ    = 7'b0100000,
    LS_KEY   = 7'b1000000
  } lex_t;

  typedef enum logic [2:0] {
    DO_NONE = 3'd0,
    DO_KEEP = 3'd1,
    DO_STR  = 3'd2,
    DO_KEY  = 3'd3,
    DO_ERR  = 3'd4,
    DO_END  = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_END  = 2'd1,
    TAIL_ERR  = 2'd2
  } tail_t;

  typedef struct packed {
    act_t act;
    lex_t nxt;
  } trans_t;

  // One queue entry: everything one character asks of the back end
  typedef struct packed {
    logic                      has_stmt;
    tail_t                     tail;
    err_t                      code;
    logic [15:0]               line;
    logic [3:0]                kw;
    logic [1:0]                nargs;
    logic [2:0][LEN_W-1:0]     lens;
  } cmd_t;

  // Byte write into the string memory
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [2:0]       lane;
    logic [7:0]       data;
  } wr_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  kw;
    logic [1:0]  arg;
    logic [63:0] data;
    logic [3:0]  bytes;
    logic        send;
    err_t        code;
    logic [15:0] line;
    logic        last;
  } res_t;

  // Keyword names, blank padded, first letter in the top byte
  localparam logic [63:0] KEY_NAMES [NKEYS] = '{
    "BAR     ", "BUTTON  ", "CHECK   ", "CYCLE   ", "GROUP   ", "LGROUP  ",
    "ITEM    ", "LIST    ", "MENU    ", "STRING  ", "TITLE   ", "VALUE   ",
    "TEXT    "
  };

  localparam logic [1:0] KEY_ARGS [NKEYS] = '{
    2'd0, 2'd1, 2'd3, 2'd1, 2'd1, 2'd1, 2'd3, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1
  };

  function automatic trans_t tr(input act_t a, input lex_t s);
    trans_t t;
    t.act = a;
    t.nxt = s;
    return t;
  endfunction

  // Lexer transition table
  function automatic trans_t next_trans(input lex_t st, input cls_t cc);
    trans_t t;
    t = tr(DO_ERR, LS_SCAN);
    case (st)
      LS_SLASH: begin
        if (cc == CC_STAR) t = tr(DO_NONE, LS_CMT);
      end
      LS_CMT: begin
        if (cc == CC_EOF) t = tr(DO_ERR, LS_SCAN);
        else if (cc == CC_STAR) t = tr(DO_NONE, LS_STAR);
        else t = tr(DO_NONE, LS_CMT);
      end
      LS_STAR: begin
        if (cc == CC_EOF) t = tr(DO_ERR, LS_SCAN);
        else if (cc == CC_SLASH) t = tr(DO_NONE, LS_SCAN);
        else t = tr(DO_NONE, LS_CMT);
      end
      LS_DQ: begin
        if (cc == CC_EOF) t = tr(DO_ERR, LS_SCAN);
        else if (cc == CC_DQ) t = tr(DO_STR, LS_SCAN);
        else t = tr(DO_KEEP, LS_DQ);
      end
      LS_SQ: begin
        if (cc == CC_EOF) t = tr(DO_ERR, LS_SCAN);
        else if (cc == CC_SQ) t = tr(DO_STR, LS_SCAN);
        else t = tr(DO_KEEP, LS_SQ);
      end
      LS_KEY: begin
        case (cc)
          CC_EOF:   t = tr(DO_KEY, LS_SCAN);
          CC_SLASH: t = tr(DO_KEY, LS_SLASH);
          CC_DQ:    t = tr(DO_KEY, LS_DQ);
          CC_SQ:    t = tr(DO_KEY, LS_SQ);
          CC_ALPHA: t = tr(DO_KEEP, LS_KEY);
          CC_BLANK: t = tr(DO_KEY, LS_SCAN);
          default:  t = tr(DO_ERR, LS_SCAN);
        endcase
      end
      default: begin
        case (cc)
          CC_EOF:   t = tr(DO_END, LS_SCAN);
          CC_SLASH: t = tr(DO_NONE, LS_SLASH);
          CC_DQ:    t = tr(DO_NONE, LS_DQ);
          CC_SQ:    t = tr(DO_NONE, LS_SQ);
          CC_ALPHA: t = tr(DO_KEEP, LS_KEY);
          CC_BLANK: t = tr(DO_NONE, LS_SCAN);
          default:  t = tr(DO_ERR, LS_SCAN);
        endcase
      end
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== src/kst_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kst_front #(
  parameter int MAX_STRING_LEN = 64,
  parameter int KEYWORD_LEN    = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    char_byte,
  input  wire logic          end_of_file,
  input  wire logic          q_full,
  output logic               push,
  output kst_pkg::cmd_t      cmd,
  output kst_pkg::wr_t       wr,
  input  wire logic          stmt_done
);

  localparam int ROWS = (MAX_STRING_LEN + 7) / 8;
  localparam int KW_W = KEYWORD_LEN * 8;

  kst_pkg::lex_t                            lex, lex_next;
  logic [15:0]                              line, line_next;
  logic [kst_pkg::LEN_W-1:0]                tok, tok_next;
  logic [KW_W-1:0]                          kw_chars, kw_chars_next;
  logic [3:0]                               pend, pend_next;
  logic [1:0]                               exp_n, exp_n_next;
  logic [1:0]                               rcv, rcv_next;
  logic                                     await_a, await_a_next;
  logic [2:0][kst_pkg::LEN_W-1:0]           lens, lens_next;
  logic                                     stmt_pending;

  logic                                     accept;
  kst_pkg::cls_t                            cls;
  kst_pkg::trans_t                          t;
  logic [kst_pkg::NKEYS-1:0]                match;
  logic                                     found;
  logic [3:0]                               found_idx;
  logic [1:0]                               slot;
  logic                                     reset_all;

  assign accept   = in_valid & in_ready;
  assign in_ready = ~q_full & ~stmt_pending;

  // Character class
  always_comb begin
    if (end_of_file) cls = kst_pkg::CC_EOF;
    else if (char_byte == 8'h2F) cls = kst_pkg::CC_SLASH;
    else if (char_byte == 8'h2A) cls = kst_pkg::CC_STAR;
    else if (char_byte == 8'h22) cls = kst_pkg::CC_DQ;
    else if (char_byte == 8'h27) cls = kst_pkg::CC_SQ;
    else if (char_byte == 8'h0A || char_byte == 8'h20 || char_byte == 8'h09)
      cls = kst_pkg::CC_BLANK;
    else if ((char_byte >= 8'h41 && char_byte <= 8'h5A) ||
             (char_byte >= 8'h61 && char_byte <= 8'h7A))
      cls = kst_pkg::CC_ALPHA;
    else cls = kst_pkg::CC_OTHER;
  end

  assign t = kst_pkg::next_trans(lex, cls);

  // Keyword lookup: parallel compare, lowest entry wins
  always_comb begin
    for (int i = 0; i < kst_pkg::NKEYS; i++) begin
      match[i] = 1'b1;
      for (int j = 0; j < KEYWORD_LEN; j++) begin
        if (kst_pkg::KEY_NAMES[i][63 - 8*j -: 8] != kw_chars[8*j +: 8]) match[i] = 1'b0;
      end
    end
    found     = 1'b0;
    found_idx = '0;
    for (int i = kst_pkg::NKEYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_idx = 4'(i);
      end
    end
    if (tok > kst_pkg::LEN_W'(KEYWORD_LEN)) found = 1'b0;
  end

  assign slot = (rcv < 2'd3) ? rcv : 2'd2;

  // Action of the table entry
  always_comb begin
    lex_next      = t.nxt;
    line_next     = line;
    tok_next      = tok;
    kw_chars_next = kw_chars;
    pend_next     = pend;
    exp_n_next    = exp_n;
    rcv_next      = rcv;
    await_a_next  = await_a;
    lens_next     = lens;
    reset_all     = 1'b0;
    cmd           = '0;
    cmd.tail      = kst_pkg::TAIL_NONE;
    cmd.code      = kst_pkg::ERR_BAD;
    wr            = '0;
    wr.row        = kst_pkg::ROW_W'(slot) * kst_pkg::ROW_W'(ROWS) +
                    kst_pkg::ROW_W'(tok >> 3);
    wr.lane       = tok[2:0];
    wr.data       = char_byte;

    if (cls == kst_pkg::CC_BLANK && char_byte == 8'h0A && line != 16'hFFFF)
      line_next = line + 16'd1;
    cmd.line = line_next;

    case (t.act)
      kst_pkg::DO_KEEP: begin
        if (tok >= kst_pkg::LEN_W'(MAX_STRING_LEN)) begin
          cmd.tail = kst_pkg::TAIL_ERR;
          cmd.code = kst_pkg::ERR_LONG;
        end else begin
          if (t.nxt == kst_pkg::LS_KEY) begin
            if (tok < kst_pkg::LEN_W'(KEYWORD_LEN))
              kw_chars_next[tok[2:0]*8 +: 8] =
                (char_byte >= 8'h61) ? char_byte - 8'd32 : char_byte;
          end else begin
            wr.en = accept;
          end
          tok_next = tok + 1'b1;
        end
      end
      kst_pkg::DO_STR: begin
        if (!await_a || rcv >= 2'd3) begin
          cmd.tail = kst_pkg::TAIL_ERR;
          cmd.code = kst_pkg::ERR_STRING;
        end else begin
          lens_next[rcv] = tok;
          tok_next       = '0;
          rcv_next       = rcv + 2'd1;
          if (rcv_next >= exp_n) begin
            cmd.has_stmt = 1'b1;
            pend_next    = '0;
            exp_n_next   = '0;
            rcv_next     = '0;
            await_a_next = 1'b0;
          end
        end
      end
      kst_pkg::DO_KEY: begin
        if (await_a) begin
          cmd.tail = kst_pkg::TAIL_ERR;
          cmd.code = kst_pkg::ERR_STRING;
        end else if (!found) begin
          cmd.tail = kst_pkg::TAIL_ERR;
          cmd.code = kst_pkg::ERR_UNKNOWN;
        end else begin
          tok_next      = '0;
          kw_chars_next = {KEYWORD_LEN{8'h20}};
          pend_next     = found_idx;
          exp_n_next    = kst_pkg::KEY_ARGS[found_idx];
          rcv_next      = '0;
          if (exp_n_next == 2'd0) cmd.has_stmt = 1'b1;
          else await_a_next = 1'b1;
          if (cls == kst_pkg::CC_EOF) begin
            if (await_a_next) begin
              cmd.tail = kst_pkg::TAIL_ERR;
              cmd.code = kst_pkg::ERR_EOF;
            end else begin
              cmd.tail = kst_pkg::TAIL_END;
            end
          end
        end
      end
      kst_pkg::DO_ERR: begin
        cmd.tail = kst_pkg::TAIL_ERR;
        cmd.code = (cls == kst_pkg::CC_EOF) ? kst_pkg::ERR_EOF : kst_pkg::ERR_BAD;
      end
      kst_pkg::DO_END: begin
        if (await_a) begin
          cmd.tail = kst_pkg::TAIL_ERR;
          cmd.code = kst_pkg::ERR_EOF;
        end else begin
          cmd.tail = kst_pkg::TAIL_END;
        end
      end
      default: ;
    endcase

    // Statement payload
    cmd.kw    = found_idx;
    cmd.nargs = kst_pkg::KEY_ARGS[found_idx];
    if (t.act == kst_pkg::DO_STR) begin
      cmd.kw    = pend;
      cmd.nargs = exp_n;
    end
    cmd.lens = lens_next;

    reset_all = (cmd.tail != kst_pkg::TAIL_NONE);
    push      = accept & (cmd.has_stmt | reset_all);
  end

  // Lexer registers
  always_ff @(posedge clk) begin
    if (rst || (accept && reset_all)) begin
      lex      <= kst_pkg::LS_SCAN;
      line     <= 16'd1;
      tok      <= '0;
      kw_chars <= {KEYWORD_LEN{8'h20}};
      pend     <= '0;
      exp_n    <= '0;
      rcv      <= '0;
      await_a  <= 1'b0;
      lens     <= '0;
    end else if (accept) begin
      lex      <= lex_next;
      line     <= line_next;
      tok      <= tok_next;
      kw_chars <= kw_chars_next;
      pend     <= pend_next;
      exp_n    <= exp_n_next;
      rcv      <= rcv_next;
      await_a  <= await_a_next;
      lens     <= lens_next;
    end
  end

  // Hold input while a statement still reads the string memory
  always_ff @(posedge clk) begin
    if (rst) begin
      stmt_pending <= 1'b0;
    end else if (push && cmd.has_stmt) begin
      stmt_pending <= 1'b1;
    end else if (stmt_done) begin
      stmt_pending <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== src/kst_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kst_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire kst_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output kst_pkg::cmd_t      head
);

  // Two-entry command queue
  kst_pkg::cmd_t entry [2];
  logic          wptr, rptr;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) entry[wptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== src/kst_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "keyword_string_tokenizer_assert.svh"
module kst_back #(
  parameter int MAX_STRING_LEN = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire kst_pkg::cmd_t q_cmd,
  output logic               q_pop,
  input  wire kst_pkg::wr_t  wr,
  output logic               stmt_done,
  output logic               out_valid,
  input  wire logic          out_ready,
  output kst_pkg::res_t      res
);

  localparam int ROWS  = (MAX_STRING_LEN + 7) / 8;
  localparam int DEPTH = 3 * ROWS;
  localparam int RAW   = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_KEY   = 5'b00010,
    S_READ  = 5'b00100,
    S_CHUNK = 5'b01000,
    S_TAIL  = 5'b10000
  } bstate_t;

  bstate_t                    state, state_next;
  kst_pkg::cmd_t              cur;
  logic [1:0]                 arg, arg_next;
  logic [kst_pkg::LEN_W-1:0]  off, off_next;
  logic [63:0]                rdata;
  logic [63:0]                mem [DEPTH];
  logic [kst_pkg::ROW_W-1:0]  raddr;

  logic                       can_load, load;
  kst_pkg::res_t              res_next;
  logic [kst_pkg::LEN_W-1:0]  len, rem, off_sum;
  logic [3:0]                 cnt;
  logic                       send;

  assign can_load = ~out_valid | out_ready;

  // String memory: byte writes from the front, row reads here
  assign raddr = kst_pkg::ROW_W'(arg) * kst_pkg::ROW_W'(ROWS) +
                 kst_pkg::ROW_W'(off >> 3);

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.row[RAW-1:0]][wr.lane*8 +: 8] <= wr.data;
    if (state == S_READ) rdata <= mem[raddr[RAW-1:0]];
  end

  // Chunk size for the current argument
  always_comb begin
    len = cur.lens[arg];
    if (len > kst_pkg::LEN_W'(MAX_STRING_LEN)) len = kst_pkg::LEN_W'(MAX_STRING_LEN);
    rem     = len - off;
    cnt     = (rem > kst_pkg::LEN_W'(8)) ? 4'd8 : rem[3:0];
    off_sum = off + kst_pkg::LEN_W'(cnt);
    send    = (off_sum >= len);
  end

  // Sequencer
  always_comb begin
    state_next = state;
    arg_next   = arg;
    off_next   = off;
    q_pop      = 1'b0;
    load       = 1'b0;
    stmt_done  = 1'b0;
    res_next       = '0;
    res_next.kind  = kst_pkg::KIND_KEY;
    res_next.code  = kst_pkg::ERR_BAD;
    res_next.line  = cur.line;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = q_cmd.has_stmt ? S_KEY : S_TAIL;
        end
      end
      S_KEY: begin
        res_next.kw   = cur.kw;
        res_next.last = (cur.nargs == 2'd0) && (cur.tail == kst_pkg::TAIL_NONE);
        if (can_load) begin
          load = 1'b1;
          if (cur.nargs == 2'd0) begin
            stmt_done  = 1'b1;
            state_next = (cur.tail == kst_pkg::TAIL_NONE) ? S_IDLE : S_TAIL;
          end else begin
            arg_next   = '0;
            off_next   = '0;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_CHUNK;
      end
      S_CHUNK: begin
        res_next.kind  = kst_pkg::KIND_CHUNK;
        res_next.kw    = cur.kw;
        res_next.arg   = arg;
        res_next.bytes = cnt;
        res_next.send  = send;
        for (int k = 0; k < 8; k++) begin
          res_next.data[8*k +: 8] = (4'(k) < cnt) ? rdata[8*k +: 8] : 8'h00;
        end
        res_next.last = send && (arg + 2'd1 >= cur.nargs) &&
                        (cur.tail == kst_pkg::TAIL_NONE);
        if (can_load) begin
          load = 1'b1;
          if (!send) begin
            off_next   = off_sum;
            state_next = S_READ;
          end else if (arg + 2'd1 < cur.nargs) begin
            arg_next   = arg + 2'd1;
            off_next   = '0;
            state_next = S_READ;
          end else begin
            stmt_done  = 1'b1;
            state_next = (cur.tail == kst_pkg::TAIL_NONE) ? S_IDLE : S_TAIL;
          end
        end
      end
      S_TAIL: begin
        res_next.kind = (cur.tail == kst_pkg::TAIL_END) ? kst_pkg::KIND_END : kst_pkg::KIND_ERR;
        res_next.code = (cur.tail == kst_pkg::TAIL_END) ? kst_pkg::ERR_BAD : cur.code;
        res_next.last = 1'b1;
        if (can_load) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_cmd;
    arg <= arg_next;
    off <= off_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res <= res_next;
  end

  `KST_ASSERT_NOW(a_chunk_size, out_valid && res.kind == kst_pkg::KIND_CHUNK, res.bytes <= 4'd8)
  `KST_ASSERT_NEXT(a_read_then_chunk, state == S_READ, state == S_CHUNK)
  `KST_ASSERT_NOW(a_pop_idle, q_pop, state == S_IDLE && q_valid)

endmodule
`default_nettype wire

// ===== src/keyword_string_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Statement tokenizer: takes one character per cycle (or an end-of-file mark)
// while in_ready is high and returns keyword, string-chunk, end and error
// items. While a finished statement is being sent, input waits: the back end
// takes the command from the queue, sends the keyword item and then each
// 8-byte chunk (one string memory row read, then the output load); receiver
// stalls and commands still queued ahead make the wait longer. End and error
// items pass through a two-entry queue and hold input only while it is full.
module keyword_string_tokenizer #(
  parameter int MAX_STRING_LEN = 64,
  parameter int KEYWORD_LEN    = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_byte,
  input  wire logic        end_of_file,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [3:0]       keyword_code,
  output logic [1:0]       arg_index,
  output logic [63:0]      chunk_data,
  output logic [3:0]       chunk_bytes,
  output logic             string_end,
  output logic [2:0]       error_code,
  output logic [15:0]      line_number,
  output logic             last
);

  logic          push, q_full, q_pop, q_valid, stmt_done;
  kst_pkg::cmd_t push_cmd, head;
  kst_pkg::wr_t  wr;
  kst_pkg::res_t res;

  kst_front #(
    .MAX_STRING_LEN(MAX_STRING_LEN),
    .KEYWORD_LEN   (KEYWORD_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_byte  (char_byte),
    .end_of_file(end_of_file),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd),
    .wr         (wr),
    .stmt_done  (stmt_done)
  );

  kst_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (head)
  );

  kst_back #(
    .MAX_STRING_LEN(MAX_STRING_LEN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (head),
    .q_pop    (q_pop),
    .wr       (wr),
    .stmt_done(stmt_done),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res      (res)
  );

  assign kind         = res.kind;
  assign keyword_code = res.kw;
  assign arg_index    = res.arg;
  assign chunk_data   = res.data;
  assign chunk_bytes  = res.bytes;
  assign string_end   = res.send;
  assign error_code   = res.code;
  assign line_number  = res.line;
  assign last         = res.last;

endmodule
`default_nettype wire

// ===== bench/keyword_string_tokenizer_tb.sv =====
`timescale 1ns / 1ps
module keyword_string_tokenizer_tb;
  import kst_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_byte = 8'd0;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [3:0]  keyword_code;
  logic [1:0]  arg_index;
  logic [63:0] chunk_data;
  logic [3:0]  chunk_bytes;
  logic        string_end;
  logic [2:0]  error_code;
  logic [15:0] line_number;
  logic        last;

  keyword_string_tokenizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_byte(char_byte), .end_of_file(end_of_file),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .keyword_code(keyword_code), .arg_index(arg_index),
    .chunk_data(chunk_data), .chunk_bytes(chunk_bytes), .string_end(string_end),
    .error_code(error_code), .line_number(line_number), .last(last)
  );

  always #1 clk = ~clk;

  // Keyword spellings and argument counts, in code order
  string word_names [13] = '{"BAR", "BUTTON", "CHECK", "CYCLE", "GROUP", "LGROUP",
                             "ITEM", "LIST", "MENU", "STRING", "TITLE", "VALUE", "TEXT"};
  int    word_args [13] = '{0, 1, 3, 1, 1, 1, 3, 2, 1, 2, 1, 2, 1};

  // Predicted tokenizer state
  lex_t       p_state;
  int         p_line;
  int         p_len;
  logic [7:0] p_word [6];
  int         p_kw;
  int         p_nargs;
  int         p_got;
  bit         p_waiting;
  logic [7:0] p_text [192];
  int         p_slen [3];

  res_t expected_items[$];
  int   mismatches = 0;
  int   chars_sent = 0;
  int   items_seen = 0;
  bit   idle_on = 1'b1;
  int   rx_hold = 0;

  function automatic void clear_lexer();
    p_state = LS_SCAN;
    p_line = 1;
    p_len = 0;
    foreach (p_word[i]) p_word[i] = 8'h20;
    p_kw = 0;
    p_nargs = 0;
    p_got = 0;
    p_waiting = 1'b0;
    foreach (p_slen[i]) p_slen[i] = 0;
  endfunction

  function automatic void push_item(kind_t k, int kw, int arg, logic [63:0] d, int nb,
                                    bit se, err_t code);
    res_t r;
    r.kind = k;
    r.kw = kw[3:0];
    r.arg = arg[1:0];
    r.data = d;
    r.bytes = nb[3:0];
    r.send = se;
    r.code = code;
    r.line = p_line[15:0];
    r.last = 1'b0;
    expected_items.push_back(r);
  endfunction

  function automatic void push_error(err_t code);
    push_item(KIND_ERR, 0, 0, 64'd0, 0, 1'b0, code);
    clear_lexer();
  endfunction

  function automatic void push_end();
    push_item(KIND_END, 0, 0, 64'd0, 0, 1'b0, ERR_BAD);
    clear_lexer();
  endfunction

  // Keyword item, then each argument in 8-byte chunks
  function automatic void push_statement();
    int off, cnt, len;
    logic [63:0] d;
    push_item(KIND_KEY, p_kw, 0, 64'd0, 0, 1'b0, ERR_BAD);
    for (int a = 0; a < p_nargs && a < 3; a++) begin
      len = p_slen[a];
      off = 0;
      do begin
        d = '0;
        cnt = (len - off > 8) ? 8 : len - off;
        for (int k = 0; k < cnt; k++) d[8*k +: 8] = p_text[a*64 + off + k];
        off += cnt;
        push_item(KIND_CHUNK, p_kw, a, d, cnt, off >= len, ERR_BAD);
      end while (off < len);
    end
    p_kw = 0;
    p_nargs = 0;
    p_got = 0;
    p_waiting = 1'b0;
  endfunction

  function automatic int match_word();
    bit hit;
    if (p_len > 6) return -1;
    for (int i = 0; i < 13; i++) begin
      hit = 1'b1;
      for (int j = 0; j < 6; j++)
        if (p_word[j] != ((j < word_names[i].len()) ? word_names[i][j] : 8'h20)) hit = 1'b0;
      if (hit) return i;
    end
    return -1;
  endfunction

  // Expected items for one accepted character
  function automatic void tokenize_char(logic [7:0] c, bit eof);
    cls_t  cc;
    act_t  act;
    lex_t  nxt;
    int    n0, k, slot;
    n0 = expected_items.size();
    if (eof) cc = CC_EOF;
    else if (c == "/") cc = CC_SLASH;
    else if (c == "*") cc = CC_STAR;
    else if (c == 8'h22) cc = CC_DQ;
    else if (c == 8'h27) cc = CC_SQ;
    else if (c == 8'h0a || c == " " || c == 8'h09) begin
      cc = CC_BLANK;
      if (c == 8'h0a && p_line < 65535) p_line++;
    end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) cc = CC_ALPHA;
    else cc = CC_OTHER;

    // Transition table
    act = DO_ERR;
    nxt = LS_SCAN;
    case (p_state)
      LS_SLASH: if (cc == CC_STAR) begin act = DO_NONE; nxt = LS_CMT; end
      LS_CMT: begin
        if (cc != CC_EOF) begin act = DO_NONE; nxt = (cc == CC_STAR) ? LS_STAR : LS_CMT; end
      end
      LS_STAR: begin
        if (cc != CC_EOF) begin act = DO_NONE; nxt = (cc == CC_SLASH) ? LS_SCAN : LS_CMT; end
      end
      LS_DQ, LS_SQ: begin
        if (cc == CC_EOF) act = DO_ERR;
        else if ((p_state == LS_DQ && cc == CC_DQ) || (p_state == LS_SQ && cc == CC_SQ))
          act = DO_STR;
        else begin act = DO_KEEP; nxt = p_state; end
      end
      LS_KEY: begin
        case (cc)
          CC_EOF, CC_BLANK: act = DO_KEY;
          CC_SLASH: begin act = DO_KEY; nxt = LS_SLASH; end
          CC_DQ:    begin act = DO_KEY; nxt = LS_DQ; end
          CC_SQ:    begin act = DO_KEY; nxt = LS_SQ; end
          CC_ALPHA: begin act = DO_KEEP; nxt = LS_KEY; end
          default:  act = DO_ERR;
        endcase
      end
      default: begin
        case (cc)
          CC_EOF:   act = DO_END;
          CC_SLASH: begin act = DO_NONE; nxt = LS_SLASH; end
          CC_DQ:    begin act = DO_NONE; nxt = LS_DQ; end
          CC_SQ:    begin act = DO_NONE; nxt = LS_SQ; end
          CC_ALPHA: begin act = DO_KEEP; nxt = LS_KEY; end
          CC_BLANK: act = DO_NONE;
          default:  act = DO_ERR;
        endcase
      end
    endcase
    p_state = nxt;

    case (act)
      DO_KEEP: begin
        if (p_len >= 64) push_error(ERR_LONG);
        else begin
          if (p_state == LS_KEY) begin
            if (p_len < 6) p_word[p_len] = (c >= "a") ? c - 8'd32 : c;
          end else begin
            slot = (p_got < 3) ? p_got : 2;
            p_text[slot*64 + p_len] = c;
          end
          p_len++;
        end
      end
      DO_STR: begin
        if (!p_waiting || p_got >= 3) push_error(ERR_STRING);
        else begin
          p_slen[p_got] = p_len;
          p_len = 0;
          p_got++;
          if (p_got >= p_nargs) push_statement();
        end
      end
      DO_KEY: begin
        if (p_waiting) push_error(ERR_STRING);
        else begin
          k = match_word();
          if (k < 0) push_error(ERR_UNKNOWN);
          else begin
            p_len = 0;
            foreach (p_word[i]) p_word[i] = 8'h20;
            p_kw = k;
            p_nargs = word_args[k];
            p_got = 0;
            if (p_nargs == 0) push_statement();
            else p_waiting = 1'b1;
            if (cc == CC_EOF) begin
              if (p_waiting) push_error(ERR_EOF);
              else push_end();
            end
          end
        end
      end
      DO_ERR: push_error((cc == CC_EOF) ? ERR_EOF : ERR_BAD);
      DO_END: begin
        if (p_waiting) push_error(ERR_EOF);
        else push_end();
      end
      default: ;
    endcase
    if (expected_items.size() > n0) expected_items[$].last = 1'b1;
  endfunction

  // One character item, with optional idle cycles ahead of it
  task automatic send_char(input logic [7:0] c, input bit eof);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      char_byte = $urandom_range(0, 255);
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    char_byte = c;
    end_of_file = eof;
    do @(posedge clk); while (!in_ready);
    tokenize_char(c, eof);
    chars_sent++;
    @(negedge clk);
    in_valid = 1'b0;
    end_of_file = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_char($urandom_range(0, 255), 1'b1);
  endtask

  task automatic drain();
    while (expected_items.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // One well-formed statement with random spelling, spacing and arguments
  task automatic rand_statement();
    int k, len;
    logic [7:0] q, ch;
    k = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) send_text("/* x */");
    if ($urandom_range(0, 2) == 0) send_char(8'h0a, 1'b0);
    for (int i = 0; i < word_names[k].len(); i++) begin
      ch = word_names[k][i];
      send_char($urandom_range(0, 1) ? ch + 8'd32 : ch, 1'b0);
    end
    if (word_args[k] == 0 || $urandom_range(0, 1)) send_char(" ", 1'b0);
    for (int a = 0; a < word_args[k]; a++) begin
      if ($urandom_range(0, 2) == 0) send_char(8'h09, 1'b0);
      q = $urandom_range(0, 1) ? 8'h22 : 8'h27;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 64) : $urandom_range(0, 12);
      send_char(q, 1'b0);
      for (int i = 0; i < len; i++) begin
        do ch = $urandom_range(0, 255); while (ch == q);
        send_char(ch, 1'b0);
      end
      send_char(q, 1'b0);
    end
  endtask

  // Receiver: long hold-off on request, else random stall bursts
  initial begin
    int gap;
    gap = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready = 1'b0;
        rx_hold--;
      end else if (gap > 0) begin
        out_ready = 1'b0;
        gap--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        gap = $urandom_range(0, 2);
      end else out_ready = 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && out_ready) begin
      items_seen++;
      if (expected_items.size() == 0) begin
        $error("unexpected item: kind %0d", kind);
        mismatches++;
      end else begin
        e = expected_items.pop_front();
        if (kind != e.kind) begin
          $error("kind: expected %0d, actual %0d", e.kind, kind); mismatches++;
        end
        if (keyword_code != e.kw) begin
          $error("keyword_code: expected %0d, actual %0d", e.kw, keyword_code); mismatches++;
        end
        if (arg_index != e.arg) begin
          $error("arg_index: expected %0d, actual %0d", e.arg, arg_index); mismatches++;
        end
        if (chunk_data != e.data) begin
          $error("chunk_data: expected %h, actual %h", e.data, chunk_data); mismatches++;
        end
        if (chunk_bytes != e.bytes) begin
          $error("chunk_bytes: expected %0d, actual %0d", e.bytes, chunk_bytes); mismatches++;
        end
        if (string_end != e.send) begin
          $error("string_end: expected %0d, actual %0d", e.send, string_end); mismatches++;
        end
        if (error_code != e.code) begin
          $error("error_code: expected %0d, actual %0d", e.code, error_code); mismatches++;
        end
        if (line_number != e.line) begin
          $error("line_number: expected %0d, actual %0d", e.line, line_number); mismatches++;
        end
        if (last != e.last) begin
          $error("last: expected %0d, actual %0d", e.last, last); mismatches++;
        end
      end
    end
  end

  // Every keyword, both quote styles, empty and multi-chunk strings, comments
  task automatic test_statements();
    send_text("bar\nButton 'x' cHeCk \"\" 'abcdefgh' \"0123456789ABCDEF!\"\n");
    send_text("cycle\"c\" group 'g' /* n\n*/ lgroup 'l' item 'a''b''c' list 'p' 'q'\n");
    send_text("menu 'm' string 's' 't' title 'T' value 'v''w' text 'e'");
    send_char(8'h0a, 1'b0);
    send_text("bar");
    send_eof();
    drain();
  endtask

  // Each error path, with the state clean between them
  task automatic test_errors();
    string bad [14] = '{"#", "*", "/x", "foo ", "buttons ", "'stray' ", "button bar ",
                        "bar#", "menu/x", "bar*", "**/", "/*/ */ \x80", "t", "check 'a'"};
    string body;
    foreach (bad[i]) begin
      send_text(bad[i]);
      if (i >= 12) send_eof();
    end
    send_text("/* open");
    send_eof();
    send_text("'open");
    send_eof();
    send_text("/");
    send_eof();
    send_text("button");
    send_eof();
    send_eof();
    body = "";
    for (int i = 0; i < 64; i++) body = {body, "z"};
    send_text({"menu '", body, "'"});
    send_text({body, "q"});
    drain();
  endtask

  // Receiver held off while statements keep arriving
  task automatic test_backpressure();
    rx_hold = 200;
    for (int i = 0; i < 2; i++) send_text("check 'abcdefghijklmnopq' 'r' 'stuvwxyz01' ");
    drain();
  endtask

  // Mostly well-formed statements, some noise and broken input
  task automatic test_random(input int n_chars);
    int start, pick;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) rand_statement();
      else if (pick < 18) send_char($urandom_range(0, 255), 1'b0);
      else send_eof();
    end
    send_char(" ", 1'b0);
    send_eof();
  endtask

  initial begin
    clear_lexer();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_statements();
    test_errors();
    test_backpressure();
    test_random(40);
    drain();
    idle_on = 1'b0;
    test_random(40);
    drain();
    if (expected_items.size() != 0) begin
      $error("%0d expected items never arrived", expected_items.size());
      mismatches++;
    end
    $display("Sent %0d characters and checked %0d result items:", chars_sent, items_seen);
    $display("all keywords, strings, comments, error paths and output stalls.");
    if (mismatches == 0) $display("keyword_string_tokenizer test passed");
    else $display("keyword_string_tokenizer test failed");
    $finish;
  end

  // Timeout
  initial begin
    #3000000;
    $display("keyword_string_tokenizer test failed");
    $finish;
  end

endmodule
